// File: sv/bfha_pkg.sv
// Shared types and constants of the best-fit heap allocator.
// Holds the segment entry layout, result and configuration structs, status codes.
// No dependencies.
package bfha_pkg;

    localparam int MAX_SEGMENTS   = 64;
    localparam int HEADER_BYTES   = 16;
    localparam int ALIGN_BYTES    = 8;      // power of two
    localparam int MAX_HEAP_BYTES = 1048576;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SZ_W   = $clog2(MAX_HEAP_BYTES) + 1;
    localparam int NEED_W = SZ_W + 1;
    localparam int ADDR_W = 32;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    typedef struct packed {
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] size;
        logic            used;
    } seg_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SZ_W-1:0]   size;
        logic              reinit;
    } cfg_t;

endpackage

// File: sv/bfha_seg_mem.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on bfha_pkg for the entry layout and depth.
module bfha_seg_mem import bfha_pkg::*; (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  seg_t             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output seg_t             rd_data
);

    seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/bfha_seq.sv
// Request sequencer: scans the segment table, then, where needed, shifts entries and
// patches the chosen segment. Depends on bfha_pkg and bfha_seg_mem.
module bfha_seq import bfha_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              start,
    input  logic              mode,
    input  logic [SZ_W-1:0]   request_bytes,
    input  logic [ADDR_W-1:0] release_address,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_MOVE   = 8'b0001_0000,
        S_FIX1   = 8'b0010_0000,
        S_FIX2   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    localparam logic [NEED_W-1:0] ALIGN_MASK = ~NEED_W'(ALIGN_BYTES - 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               mode_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   issue_reg;
    logic               pv_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_reg;
    seg_t               bseg_reg;
    logic [SZ_W-1:0]    bdiff_reg;
    seg_t               prev_reg;
    seg_t               lseg_reg;
    logic               left_reg;
    logic               right_reg;
    logic [SZ_W-1:0]    rsize_reg;
    logic               split_reg;
    logic [CNT_W-1:0]   mv_cnt_reg;
    logic [IDX_W-1:0]   mv_src_reg;
    logic               mv_up_reg;
    logic [1:0]         mv_off_reg;
    logic               wpv_reg;
    logic [IDX_W-1:0]   wpaddr_reg;
    result_t            res_reg;

    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    seg_t               wr_data, rd_data;

    logic               fits, better, match;
    logic [SZ_W-1:0]    diff;
    logic [ADDR_W-1:0]  seg_addr;
    logic [SZ_W-1:0]    merged;
    logic [1:0]         mdist;
    logic [IDX_W-1:0]   target;
    logic               split_now;

    bfha_seg_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign diff     = rd_data.size - need_reg[SZ_W-1:0];
    assign fits     = !rd_data.used && ({1'b0, rd_data.size} >= need_reg);
    assign better   = fits && (!found_reg || diff < bdiff_reg);
    assign seg_addr = cfg.base + ADDR_W'(rd_data.start) + ADDR_W'(HEADER_BYTES);
    assign match    = rd_data.used && (seg_addr == addr_reg);

    assign mdist  = {1'b0, left_reg} + {1'b0, right_reg};
    assign merged = (left_reg ? lseg_reg.size : '0) + bseg_reg.size
                  + (right_reg ? rsize_reg : '0);
    assign target = left_reg ? best_reg - IDX_W'(1) : best_reg;

    assign split_now = (bdiff_reg > SZ_W'(2 * HEADER_BYTES))
                     && (count_reg < CNT_W'(MAX_SEGMENTS));

    assign idle      = (state_reg == S_IDLE) && !cfg.reinit;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            S_INIT: begin
                wr_en      = 1'b1;
                wr_data    = '{start: '0, size: cfg.size, used: 1'b0};
                count_next = CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg.reinit) begin
                    state_next = S_INIT;
                end else if (start) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en   = issue_reg < count_reg;
                rd_addr = issue_reg[IDX_W-1:0];
                if (!rd_en && !pv_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!found_reg) begin
                    state_next = S_DONE;
                end else if (!mode_reg && !split_now) begin
                    state_next = S_FIX1;
                end else begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                rd_en   = mv_cnt_reg != '0;
                rd_addr = mv_src_reg;
                wr_en   = wpv_reg;
                wr_addr = wpaddr_reg;
                wr_data = rd_data;
                if (!rd_en && !wpv_reg) begin
                    state_next = S_FIX1;
                end
            end
            S_FIX1: begin
                wr_en = 1'b1;
                if (mode_reg) begin
                    wr_addr    = target;
                    wr_data    = '{start: left_reg ? lseg_reg.start : bseg_reg.start,
                                   size: merged, used: 1'b0};
                    count_next = count_reg - CNT_W'(mdist);
                    state_next = S_DONE;
                end else begin
                    wr_addr    = best_reg;
                    wr_data    = '{start: bseg_reg.start,
                                   size: split_reg ? need_reg[SZ_W-1:0] : bseg_reg.size,
                                   used: 1'b1};
                    state_next = split_reg ? S_FIX2 : S_DONE;
                end
            end
            S_FIX2: begin
                wr_en      = 1'b1;
                wr_addr    = best_reg + IDX_W'(1);
                wr_data    = '{start: bseg_reg.start + need_reg[SZ_W-1:0],
                               size: bdiff_reg, used: 1'b0};
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            count_reg <= CNT_W'(1);
            pv_reg    <= 1'b0;
            wpv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pv_reg    <= (state_reg == S_SCAN) && rd_en;
            wpv_reg   <= (state_reg == S_MOVE) && rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                mode_reg  <= mode;
                need_reg  <= (NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES)
                             + NEED_W'(ALIGN_BYTES - 1)) & ALIGN_MASK;
                addr_reg  <= release_address;
                issue_reg <= '0;
                found_reg <= 1'b0;
                left_reg  <= 1'b0;
                right_reg <= 1'b0;
                prev_reg  <= '{start: '0, size: '0, used: 1'b1};
            end
            S_SCAN: begin
                issue_reg <= issue_reg + CNT_W'(1);
                pidx_reg  <= issue_reg[IDX_W-1:0];
                if (pv_reg) begin
                    prev_reg <= rd_data;
                    if (!mode_reg) begin
                        if (better) begin
                            found_reg <= 1'b1;
                            best_reg  <= pidx_reg;
                            bseg_reg  <= rd_data;
                            bdiff_reg <= diff;
                        end
                    end else begin
                        if (match && !found_reg) begin
                            found_reg <= 1'b1;
                            best_reg  <= pidx_reg;
                            bseg_reg  <= rd_data;
                            lseg_reg  <= prev_reg;
                            left_reg  <= !prev_reg.used;
                        end
                        // entry just after the freed one
                        if (found_reg && pidx_reg == best_reg + IDX_W'(1)) begin
                            right_reg <= !rd_data.used;
                            rsize_reg <= rd_data.size;
                        end
                    end
                end
            end
            S_DECIDE: begin
                split_reg <= split_now;
                mv_up_reg <= !mode_reg;
                if (!mode_reg) begin
                    // open a gap after the chosen entry
                    mv_cnt_reg <= count_reg - CNT_W'(best_reg) - CNT_W'(1);
                    mv_src_reg <= IDX_W'(count_reg - CNT_W'(1));
                    mv_off_reg <= 2'd1;
                end else begin
                    // close the gap left by merged neighbours
                    mv_cnt_reg <= count_reg - CNT_W'(best_reg) - CNT_W'(1)
                                - CNT_W'(right_reg);
                    mv_src_reg <= best_reg + IDX_W'(1) + IDX_W'(right_reg);
                    mv_off_reg <= mdist;
                end
                if (!found_reg) begin
                    res_reg <= '{status: mode_reg ? STAT_UNKNOWN : STAT_NOFIT, addr: '0};
                end
            end
            S_MOVE: begin
                if (rd_en) begin
                    mv_cnt_reg <= mv_cnt_reg - CNT_W'(1);
                    mv_src_reg <= mv_up_reg ? mv_src_reg - IDX_W'(1)
                                            : mv_src_reg + IDX_W'(1);
                    wpaddr_reg <= mv_up_reg ? mv_src_reg + IDX_W'(1)
                                            : mv_src_reg - IDX_W'(mv_off_reg);
                end
            end
            S_FIX1: begin
                res_reg <= '{status: STAT_DONE,
                             addr: mode_reg ? '0 : cfg.base + ADDR_W'(bseg_reg.start)
                                                   + ADDR_W'(HEADER_BYTES)};
            end
            default: begin
            end
        endcase
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_write_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ({1'b0, wr_addr} <= count_reg))
        else $error("table write beyond the live entries");

    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIX2) |-> (count_reg < CNT_W'(MAX_SEGMENTS)))
        else $error("split with a full table");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same entry in one cycle");

endmodule

// File: sv/best_fit_heap_allocator.sv
// Flow: an accepted item goes through the scan of the live entries, a decide step, entry
// shifting where needed, the patch writes of the chosen segment, and the output register.
// Items are taken one at a time: a new one is accepted only when the sequencer is idle again.
// Reset: synchronous, active low; entry zero is written after reset and after each heap
// size write seen while the sequencer is idle, and the input is not ready meanwhile.
module best_fit_heap_allocator import bfha_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [SZ_W-1:0]   s_request_bytes,
    input  logic [ADDR_W-1:0] s_release_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [ADDR_W-1:0] m_granted_address
);

    logic [ADDR_W-1:0] base_reg;
    logic [SZ_W-1:0]   size_reg;
    logic              reinit_reg;
    logic [SZ_W-1:0]   size_wr;
    cfg_t              cfg;
    logic              seq_idle, res_valid, res_ready;
    result_t           res;
    logic              m_valid_reg;
    result_t           out_reg;

    assign size_wr = (cfg_wr_data[SZ_W-1:0] > SZ_W'(MAX_HEAP_BYTES))
                   ? SZ_W'(MAX_HEAP_BYTES) : cfg_wr_data[SZ_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            size_reg   <= SZ_W'(MAX_HEAP_BYTES);
            reinit_reg <= 1'b0;
        end else begin
            reinit_reg <= cfg_wr_en && (cfg_addr == REG_HEAP_SIZE);
            if (cfg_wr_en && cfg_addr == REG_HEAP_BASE) begin
                base_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_addr == REG_HEAP_SIZE) begin
                size_reg <= size_wr;
            end
        end
    end

    assign cfg = '{base: base_reg, size: size_reg, reinit: reinit_reg};

    bfha_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .start           (s_valid && s_ready),
        .mode            (s_mode),
        .request_bytes   (s_request_bytes),
        .release_address (s_release_address),
        .idle            (seq_idle),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign s_ready   = seq_idle;
    assign res_ready = !m_valid_reg || m_ready;

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_granted_address = out_reg.addr;

endmodule
